// ===== hdl/bup_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the bounded UV projection block.
// No dependencies; bup_cordic, bup_div and bounded_uv_projection import this package.
package bup_pkg;

  localparam int CW = 47;            // CORDIC datapath width
  localparam int MW = 41;            // magnitude width used for scaling
  localparam int AW = 26;            // angle width, units of 2^-24 turn
  localparam int CORDIC_STEPS = 21;
  localparam int HALF_TURN = 8388608;
  localparam int INV_GAIN = 39797;   // 1/K in Q16
  localparam logic [16:0] Q_HALF = 17'd32768;
  localparam logic [16:0] Q_ONE = 17'd65536;

  localparam logic OP_ACC = 1'b0;
  localparam logic OP_PROJ = 1'b1;

  localparam logic [1:0] MODE_PLANAR = 2'd0;
  localparam logic [1:0] MODE_CYL = 2'd1;
  localparam logic [1:0] MODE_SPH = 2'd2;

  localparam logic [1:0] AXIS_ZY = 2'd0;
  localparam logic [1:0] AXIS_XZ = 2'd1;
  localparam logic [1:0] AXIS_XY = 2'd2;

  localparam logic CFG_MAP_MODE = 1'b0;
  localparam logic CFG_PLANAR_AXIS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_NU_GO, S_NU_WAIT, S_NV_GO, S_NV_WAIT, S_AU_GO, S_AU_WAIT,
    S_H1_GO, S_H1_WAIT, S_MUL, S_H2_GO, S_H2_WAIT, S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cordic_state_t;

  typedef enum logic {D_IDLE, D_RUN} div_state_t;

  typedef struct packed {
    logic start;
    logic scale_en;
  } cordic_req_t;

  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0: v = 22'd2097152;
      5'd1: v = 22'd1238021;
      5'd2: v = 22'd654136;
      5'd3: v = 22'd332050;
      5'd4: v = 22'd166669;
      5'd5: v = 22'd83416;
      5'd6: v = 22'd41718;
      5'd7: v = 22'd20860;
      5'd8: v = 22'd10430;
      5'd9: v = 22'd5215;
      5'd10: v = 22'd2608;
      5'd11: v = 22'd1304;
      5'd12: v = 22'd652;
      5'd13: v = 22'd326;
      5'd14: v = 22'd163;
      5'd15: v = 22'd81;
      5'd16: v = 22'd41;
      5'd17: v = 22'd20;
      5'd18: v = 22'd10;
      5'd19: v = 22'd5;
      5'd20: v = 22'd3;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // round an angle sum (2^-24 turn) to Q1.16 and clamp to [0,1]
  function automatic logic [16:0] to_q16(input logic signed [26:0] s);
    logic signed [27:0] t;
    logic signed [27:0] q;
    logic [16:0] r;
    t = 28'(s) + 28'sd128;
    q = t >>> 8;
    if (t < 0) r = 17'd0;
    else if (q > 28'sd65536) r = Q_ONE;
    else r = q[16:0];
    return r;
  endfunction

endpackage

// ===== hdl/bup_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: valid/ready plus one vertex word.
// Depends on nothing.
interface bup_in_if;
  logic valid;
  logic ready;
  logic op;
  logic first_vertex;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;

  modport source(output valid, op, first_vertex, x_coord, y_coord, z_coord, input ready);
  modport sink(input valid, op, first_vertex, x_coord, y_coord, z_coord, output ready);
endinterface

// ===== hdl/bup_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready plus one UV word.
// Depends on nothing.
interface bup_out_if;
  logic valid;
  logic ready;
  logic [16:0] u_coord;
  logic [16:0] v_coord;
  logic no_bounds;

  modport source(output valid, u_coord, v_coord, no_bounds, input ready);
  modport sink(input valid, u_coord, v_coord, no_bounds, output ready);
endinterface

// ===== hdl/bup_cordic.sv =====
`timescale 1ns / 1ps
// Iterative vectoring CORDIC with pre-scaling: one shift or one rotation per cycle.
// Depends on bup_pkg.
module bup_cordic import bup_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_req_t          req,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [MW-1:0]        m_in,
  output logic                 done,
  output logic signed [CW-1:0] x_out,
  output logic signed [AW-1:0] ang_out,
  output logic [5:0]           shamt
);

  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  cordic_state_t st_r, st_nxt;
  logic signed [CW-1:0] x_r, y_r;
  logic [MW-1:0] m_r;
  logic signed [AW-1:0] a_r;
  logic [4:0] i_r;
  logic flip_r, done_r;
  logic [5:0] shamt_r;

  logic norm_end;
  logic signed [CW-1:0] xs, ys;
  logic signed [AW-1:0] tab, a_wrap;

  assign norm_end = (m_r == '0) || m_r[MW-1];
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign tab = AW'(atan_lut(i_r));
  assign a_wrap = a_r + AW'(HALF_TURN);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      C_IDLE: if (req.start) st_nxt = C_NORM;
      C_NORM: if (norm_end) st_nxt = C_ITER;
      C_ITER: if (i_r == LAST) st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == C_ITER) && (i_r == LAST);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          x_r <= x_in;
          y_r <= y_in;
          m_r <= req.scale_en ? m_in : {1'b1, {(MW-1){1'b0}}};
          shamt_r <= '0;
        end
      end
      C_NORM: begin
        if (norm_end) begin
          flip_r <= x_r[CW-1];
          if (x_r[CW-1]) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
          a_r <= '0;
          i_r <= '0;
        end else if (m_r[MW-1:MW-8] == '0) begin
          x_r <= x_r <<< 8;
          y_r <= y_r <<< 8;
          m_r <= m_r << 8;
          shamt_r <= shamt_r + 6'd8;
        end else begin
          x_r <= x_r <<< 1;
          y_r <= y_r <<< 1;
          m_r <= m_r << 1;
          shamt_r <= shamt_r + 6'd1;
        end
      end
      C_ITER: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          a_r <= a_r + tab;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          a_r <= a_r - tab;
        end
        i_r <= i_r + 5'd1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign x_out = x_r;
  assign shamt = shamt_r;
  // undo the left-half-plane flip, keeping the angle in (-half, half]
  assign ang_out = !flip_r ? a_r
                 : (a_wrap > AW'(HALF_TURN)) ? a_wrap - AW'(2 * HALF_TURN) : a_wrap;

endmodule

// ===== hdl/bup_div.sv =====
`timescale 1ns / 1ps
// Range normalizer: (val-lo)/(hi-lo) in Q1.16 by restoring division, one bit per cycle.
// Depends on bup_pkg.
module bup_div import bup_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] val,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  output logic               done,
  output logic [16:0]        q
);

  div_state_t st_r, st_nxt;
  logic [31:0] rem_r, r_r;
  logic [16:0] num_r, q_r;
  logic [4:0] cnt_r;
  logic done_r;

  logic signed [32:0] rng, dif;
  logic [48:0] numer;
  logic [32:0] trial;
  logic fast;

  assign rng = 33'(hi) - 33'(lo);
  assign dif = 33'(val) - 33'(lo);
  assign numer = {1'b0, dif[31:0], 16'd0} + 49'(rng[32:1]);
  assign fast = (rng <= 0) || (dif <= 0) || (dif >= rng);
  assign trial = {rem_r, num_r[16]};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      D_IDLE: if (start && !fast) st_nxt = D_RUN;
      D_RUN: if (cnt_r == 5'd16) st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == D_IDLE && start && fast) || (st_r == D_RUN && cnt_r == 5'd16);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      D_IDLE: begin
        if (start) begin
          if (rng <= 0) q_r <= Q_HALF;
          else if (dif <= 0) q_r <= 17'd0;
          else if (dif >= rng) q_r <= Q_ONE;
          rem_r <= numer[48:17];
          num_r <= numer[16:0];
          r_r <= rng[31:0];
          cnt_r <= '0;
        end
      end
      D_RUN: begin
        if (trial >= {1'b0, r_r}) begin
          rem_r <= 32'(trial - {1'b0, r_r});
          q_r <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= trial[31:0];
          q_r <= {q_r[15:0], 1'b0};
        end
        num_r <= {num_r[15:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q = q_r;

endmodule

// ===== hdl/bounded_uv_projection.sv =====
`timescale 1ns / 1ps
// Bounded UV projection: bounding-box accumulation and planar/cylindrical/spherical UV mapping.
// Depends on bup_pkg, bup_in_if, bup_out_if, bup_cordic and bup_div.
//
// Use: stream accumulate words (op=0) to build the box, first_vertex=1 restarts it; then
// stream project words (op=1), each giving one UV word on out_ch. Registers map_mode and
// planar_axis are written through cfg_we/cfg_idx/cfg_wdata; the user must write them only
// while the block is idle, since the block itself does not enforce it. One word is handled
// at a time: in_ch.ready is high only when the block is idle. Accumulate words give no
// result. Project words run a sequencer over one shared restoring divider and one shared
// vectoring CORDIC (pre-scaling shifts plus 21 rotations a run): planar runs the divider
// twice, cylindrical the CORDIC then the divider, spherical the CORDIC up to three times;
// a project word before any bounds goes straight to the result with no_bounds set.
// The result sits in the output register until out_ch.ready; a stalled receiver holds
// the block and no new word is taken meanwhile.
// Reset (synchronous, rst_n low) clears the box, map_mode to planar, planar_axis to 1.
module bounded_uv_projection import bup_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bup_in_if.sink      in_ch,
  bup_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [1:0]  cfg_wdata
);

  seq_state_t st_r, st_nxt;
  logic [1:0] mode_r, axis_r;
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic signed [31:0] p_r [3];
  logic signed [34:0] d_r [3];
  logic seen_r;
  logic [16:0] u_r, v_r;
  logic nb_r;
  logic signed [CW-1:0] kx_r, h_r;
  logic [5:0] shamt_r;

  logic acc_go, proj_go, restart, is_cyl, is_sph;
  logic signed [31:0] pin [3];
  logic [1:0] k_u, k_v, k_sel;
  logic [34:0] ad [3];
  logic [MW-1:0] m_xz, m_all;
  seq_state_t after_au;

  cordic_req_t creq;
  logic signed [CW-1:0] cx, cy;
  logic [MW-1:0] cm;
  logic c_done;
  logic signed [CW-1:0] c_x;
  logic signed [AW-1:0] c_ang;
  logic [5:0] c_shamt;
  logic div_start, div_done;
  logic [16:0] div_q;
  logic signed [63:0] prod;

  assign pin[0] = in_ch.x_coord;
  assign pin[1] = in_ch.y_coord;
  assign pin[2] = in_ch.z_coord;
  assign acc_go = (st_r == S_IDLE) && in_ch.valid && (in_ch.op == OP_ACC);
  assign proj_go = (st_r == S_IDLE) && in_ch.valid && (in_ch.op == OP_PROJ);
  assign restart = in_ch.first_vertex || !seen_r;
  assign is_cyl = (mode_r == MODE_CYL);
  assign is_sph = (mode_r == MODE_SPH);

  assign k_u = (axis_r == AXIS_ZY) ? 2'd2 : 2'd0;
  assign k_v = (is_cyl || axis_r == AXIS_ZY || axis_r == AXIS_XY) ? 2'd1 : 2'd2;
  assign k_sel = (st_r == S_NU_GO) ? k_u : k_v;

  always_comb begin
    for (int k = 0; k < 3; k++) ad[k] = d_r[k][34] ? 35'(-d_r[k]) : 35'(d_r[k]);
  end
  assign m_xz = MW'((ad[0] > ad[2]) ? ad[0] : ad[2]);
  assign m_all = (MW'(ad[1]) > m_xz) ? MW'(ad[1]) : m_xz;

  assign after_au = is_cyl ? S_NV_GO : ((d_r[1] == '0) ? S_OUT : S_H1_GO);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (proj_go) st_nxt = seen_r ? S_DISPATCH : S_OUT;
      S_DISPATCH: begin
        if (is_sph && d_r[0] == '0 && d_r[1] == '0 && d_r[2] == '0) st_nxt = S_OUT;
        else if (is_cyl || is_sph) st_nxt = S_AU_GO;
        else st_nxt = S_NU_GO;
      end
      S_NU_GO: st_nxt = S_NU_WAIT;
      S_NU_WAIT: if (div_done) st_nxt = S_NV_GO;
      S_NV_GO: st_nxt = S_NV_WAIT;
      S_NV_WAIT: if (div_done) st_nxt = S_OUT;
      S_AU_GO: st_nxt = (d_r[2] == '0) ? after_au : S_AU_WAIT;
      S_AU_WAIT: if (c_done) st_nxt = after_au;
      S_H1_GO: st_nxt = S_H1_WAIT;
      S_H1_WAIT: if (c_done) st_nxt = S_MUL;
      S_MUL: st_nxt = S_H2_GO;
      S_H2_GO: st_nxt = S_H2_WAIT;
      S_H2_WAIT: if (c_done) st_nxt = S_OUT;
      S_OUT: if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (st_r == S_IDLE);
    out_ch.valid = (st_r == S_OUT);
    div_start = (st_r == S_NU_GO) || (st_r == S_NV_GO);
    creq.start = ((st_r == S_AU_GO) && d_r[2] != '0) || (st_r == S_H1_GO) || (st_r == S_H2_GO);
    creq.scale_en = (st_r != S_H2_GO);
    cx = {{(CW-35){d_r[0][34]}}, d_r[0]};
    cy = {{(CW-35){d_r[2][34]}}, d_r[2]};
    cm = m_xz;
    case (st_r)
      S_H1_GO: cm = m_all;
      S_H2_GO: begin
        cx = h_r;
        cy = {{(CW-35){d_r[1][34]}}, d_r[1]} <<< shamt_r;
      end
      default: ;
    endcase
  end

  assign out_ch.u_coord = u_r;
  assign out_ch.v_coord = v_r;
  assign out_ch.no_bounds = nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mode_r <= MODE_PLANAR;
      axis_r <= AXIS_XZ;
      seen_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= '0;
        hi_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAP_MODE: mode_r <= cfg_wdata;
          CFG_PLANAR_AXIS: axis_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc_go) begin
        seen_r <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (restart || pin[k] < lo_r[k]) lo_r[k] <= pin[k];
          if (restart || pin[k] > hi_r[k]) hi_r[k] <= pin[k];
        end
      end
    end
  end

  assign prod = 64'(kx_r) * 64'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (proj_go) begin
      u_r <= '0;
      v_r <= '0;
      nb_r <= !seen_r;
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= pin[k];
        d_r[k] <= {pin[k][31], pin[k][31], pin[k], 1'b0}
                  - (35'(lo_r[k]) + 35'(hi_r[k]));
      end
    end
    case (st_r)
      S_DISPATCH: if (is_sph) begin
        u_r <= Q_HALF;
        v_r <= Q_HALF;
      end
      S_AU_GO: if (d_r[2] == '0) u_r <= d_r[0][34] ? Q_ONE : Q_HALF;
      S_AU_WAIT: if (c_done) u_r <= to_q16({c_ang[AW-1], c_ang} + 27'(HALF_TURN));
      S_NU_WAIT: if (div_done) u_r <= div_q;
      S_NV_WAIT: if (div_done) v_r <= div_q;
      S_H1_WAIT: if (c_done) begin
        kx_r <= c_x;
        shamt_r <= c_shamt;
      end
      S_MUL: h_r <= prod[63] ? '0 : CW'(prod >>> 16);
      S_H2_WAIT: if (c_done) v_r <= to_q16({c_ang, 1'b0} + 27'(HALF_TURN));
      default: ;
    endcase
  end

  bup_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .x_in(cx), .y_in(cy), .m_in(cm),
    .done(c_done), .x_out(c_x), .ang_out(c_ang), .shamt(c_shamt)
  );

  bup_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .val(p_r[k_sel]), .lo(lo_r[k_sel]), .hi(hi_r[k_sel]),
    .done(div_done), .q(div_q)
  );

endmodule

// ===== hdl/bup_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for bounded_uv_projection, bound to the top level.
// Depends on bounded_uv_projection.
module bup_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] u_coord,
  input logic [16:0] v_coord,
  input logic        no_bounds
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(u_coord) && $stable(v_coord))
    else $error("result word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_nb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_bounds |-> u_coord == 17'd0 && v_coord == 17'd0)
    else $error("no_bounds result with nonzero UV");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> u_coord <= 17'd65536 && v_coord <= 17'd65536)
    else $error("UV out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bounded_uv_projection bup_chk u_bup_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .u_coord(out_ch.u_coord), .v_coord(out_ch.v_coord),
  .no_bounds(out_ch.no_bounds)
);
